// ===== rtl/core/psp_pkg.sv =====
// Shared types and constants for the printf conversion specification parser.
// Used by psp_step and printf_spec_parser; depends on nothing else.

package psp_pkg;

  // Default sizes of the accumulators and the byte counter
  localparam int VALUE_BITS_DEF = 31;
  localparam int COUNT_BITS_DEF = 16;

  // Characters the parser recognises
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_Z     = 8'h7A;

  // Bit positions in the flag vector
  localparam int FLG_MINUS = 0;
  localparam int FLG_ZERO  = 1;
  localparam int FLG_PLUS  = 2;
  localparam int FLG_SPACE = 3;
  localparam int FLG_HASH  = 4;

  // Length modifier codes
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_HH   = 3'd1;
  localparam logic [2:0] LEN_H    = 3'd2;
  localparam logic [2:0] LEN_LL   = 3'd3;
  localparam logic [2:0] LEN_L    = 3'd4;
  localparam logic [2:0] LEN_Z    = 3'd5;

  // Parser phases
  typedef enum logic [8:0] {
    PH_FLAGS  = 9'b000000001,
    PH_WDIG   = 9'b000000010,
    PH_WDONE  = 9'b000000100,
    PH_PSTART = 9'b000001000,
    PH_PDIG   = 9'b000010000,
    PH_PDONE  = 9'b000100000,
    PH_LEN_H  = 9'b001000000,
    PH_LEN_L  = 9'b010000000,
    PH_CONV   = 9'b100000000
  } psp_phase_t;

  // Narrow control state of the parser
  typedef struct packed {
    psp_phase_t  phase;
    logic [4:0]  flags;
    logic        prec_present;
    logic [2:0]  len;
  } psp_ctl_t;

  // One input transfer
  typedef struct packed {
    logic        [7:0]  ch;
    logic signed [31:0] star_arg;
  } psp_in_t;

  // One result transfer
  typedef struct packed {
    logic        left_just;
    logic        fill_zero;
    logic        plus_sign;
    logic        blank_sign;
    logic        hash_style;
    logic [30:0] field_width;
    logic        has_prec;
    logic [30:0] prec_value;
    logic [2:0]  length_code;
    logic [7:0]  conversion;
    logic [15:0] consumed;
  } psp_out_t;

endpackage

// ===== rtl/core/printf_spec_parser.sv =====
// Top level of the printf conversion specification parser.
// Depends on psp_pkg and psp_step.
//
// Usage:
//   The input channel (in_valid, in_stall, in_data) carries the bytes that
//   follow a percent sign, one byte per transfer, each with a signed star
//   argument that is used when the byte is an asterisk in a width or
//   precision slot. The result channel (out_valid, out_stall, out_data)
//   carries one result per specification: flags, width, precision, length
//   code, conversion byte and byte count. A conversion byte or a NUL ends a
//   specification; all other bytes produce no result.
//   Throughput is one byte per cycle while in_stall is low. A byte lands in
//   the input register on its transfer and is parsed from there, which
//   updates the parsing state once per byte; the result of the byte that
//   ended a specification goes to the output register, which drives
//   out_valid, or to the skid register while the output register is held.
//   When the receiver stalls, the pending result holds in the output
//   register and one more result fits in a skid register; only when the skid
//   register is full and a byte waits in the input register does in_stall
//   rise. Bytes that produce no result flow on while the skid is empty.
//   Reset (rst_n low, synchronous) empties every stage and returns the parser
//   to the flags phase with all fields and the count cleared.

module printf_spec_parser #(
  parameter int VALUE_BITS = psp_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = psp_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  psp_pkg::psp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output psp_pkg::psp_out_t out_data
);

  // Input register
  logic              s1_valid_r;
  psp_pkg::psp_in_t  s1_data_r;

  // Parser state
  psp_pkg::psp_ctl_t     ctl_r;
  psp_pkg::psp_ctl_t     ctl_nxt;
  logic [VALUE_BITS-1:0] width_r;
  logic [VALUE_BITS-1:0] width_nxt;
  logic [VALUE_BITS-1:0] prec_r;
  logic [VALUE_BITS-1:0] prec_nxt;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [COUNT_BITS-1:0] cnt_nxt;

  // Output and skid registers
  logic              out_valid_r;
  psp_pkg::psp_out_t out_data_r;
  logic              skid_valid_r;
  psp_pkg::psp_out_t skid_data_r;

  logic              in_take;
  logic              adv;
  logic              out_take;
  logic              emit;
  psp_pkg::psp_out_t result;

  assign in_stall  = s1_valid_r & skid_valid_r;
  assign in_take   = in_valid & ~in_stall;
  assign adv       = s1_valid_r & ~skid_valid_r;
  assign out_take  = out_valid_r & ~out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  psp_step #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .item_i    (s1_data_r),
    .ctl_i     (ctl_r),
    .width_i   (width_r),
    .prec_i    (prec_r),
    .cnt_i     (cnt_r),
    .ctl_nxt   (ctl_nxt),
    .width_nxt (width_nxt),
    .prec_nxt  (prec_nxt),
    .cnt_nxt   (cnt_nxt),
    .emit_o    (emit),
    .result_o  (result)
  );

  // Load the input register on a transfer, drop it once parsed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_data_r <= in_data;
  end

  // Advance the parser state by one byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.phase        <= psp_pkg::PH_FLAGS;
      ctl_r.flags        <= '0;
      ctl_r.prec_present <= 1'b0;
      ctl_r.len          <= psp_pkg::LEN_NONE;
      width_r            <= '0;
      prec_r             <= '0;
      cnt_r              <= '0;
    end else if (adv) begin
      ctl_r   <= ctl_nxt;
      width_r <= width_nxt;
      prec_r  <= prec_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Output register with skid: refill from skid first, else from the parser
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (adv && emit) begin
      if (!out_valid_r || out_take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) out_data_r <= skid_data_r;
    end else if (adv && emit) begin
      if (!out_valid_r || out_take) begin
        out_data_r <= result;
      end else begin
        skid_data_r <= result;
      end
    end
  end

  // The skid register only fills behind a held output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while output register is empty");

  // A finished specification leaves the parser cleared
  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && emit) |=> (ctl_r.phase == psp_pkg::PH_FLAGS && cnt_r == '0 &&
                       width_r == '0 && prec_r == '0))
    else $error("parser state not cleared after a result");

  // The byte count never falls within a specification
  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !emit) |=> (cnt_r >= $past(cnt_r)))
    else $error("byte count decreased inside a specification");

  // No precision value without a precision
  a_prec_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.has_prec || out_data_r.prec_value == '0))
    else $error("precision value set without a precision");

endmodule

// ===== rtl/core/psp_step.sv =====
// Next-state and result logic of the parser for one format byte.
// Depends on psp_pkg.

module psp_step #(
  parameter int VALUE_BITS = psp_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = psp_pkg::COUNT_BITS_DEF
) (
  input  psp_pkg::psp_in_t         item_i,
  input  psp_pkg::psp_ctl_t        ctl_i,
  input  logic [VALUE_BITS-1:0]    width_i,
  input  logic [VALUE_BITS-1:0]    prec_i,
  input  logic [COUNT_BITS-1:0]    cnt_i,
  output psp_pkg::psp_ctl_t        ctl_nxt,
  output logic [VALUE_BITS-1:0]    width_nxt,
  output logic [VALUE_BITS-1:0]    prec_nxt,
  output logic [COUNT_BITS-1:0]    cnt_nxt,
  output logic                     emit_o,
  output psp_pkg::psp_out_t        result_o
);

  localparam int AW = VALUE_BITS + 4;
  localparam logic [VALUE_BITS-1:0] VMAX = '1;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [7:0]            ch;
  logic [31:0]           raw;
  logic                  neg;
  logic [31:0]           mag32;
  logic [VALUE_BITS-1:0] star_val;
  logic                  is_digit;
  logic                  is_flag;
  logic [VALUE_BITS-1:0] dig_op;
  logic [AW-1:0]         prod;
  logic [VALUE_BITS-1:0] dig_val;
  logic [COUNT_BITS-1:0] cnt_bump;
  logic                  consume;
  logic                  tail_req;
  logic                  tail_dot;
  logic                  emit_req;

  assign ch  = item_i.ch;
  assign raw = item_i.star_arg;
  assign neg = raw[31];

  // Magnitude of the star argument, clamped to the accumulator range
  assign mag32    = neg ? (~raw + 32'd1) : raw;
  assign star_val = (mag32 > 32'(VMAX)) ? VMAX : mag32[VALUE_BITS-1:0];

  assign is_digit = (ch inside {[psp_pkg::CH_0:psp_pkg::CH_9]});
  assign is_flag  = (ch inside {psp_pkg::CH_MINUS, psp_pkg::CH_0, psp_pkg::CH_PLUS,
                                psp_pkg::CH_SPACE, psp_pkg::CH_HASH});

  // Shared times-ten-plus-digit unit; width phases use the width accumulator
  assign dig_op  = (ctl_i.phase == psp_pkg::PH_FLAGS || ctl_i.phase == psp_pkg::PH_WDIG)
                   ? width_i : prec_i;
  assign prod    = (AW'(dig_op) << 3) + (AW'(dig_op) << 1) + AW'(ch[3:0]);
  assign dig_val = (prod > AW'(VMAX)) ? VMAX : prod[VALUE_BITS-1:0];

  // Saturating byte counter increment
  assign cnt_bump = (cnt_i == CMAX) ? cnt_i : cnt_i + COUNT_BITS'(1);

  always_comb begin
    ctl_nxt   = ctl_i;
    width_nxt = width_i;
    prec_nxt  = prec_i;
    cnt_nxt   = cnt_i;
    consume   = 1'b0;
    tail_req  = 1'b0;
    tail_dot  = 1'b0;
    emit_req  = 1'b0;

    // Phase-specific handling
    case (ctl_i.phase)
      psp_pkg::PH_FLAGS: begin
        if (is_flag) begin
          case (ch)
            psp_pkg::CH_MINUS: ctl_nxt.flags[psp_pkg::FLG_MINUS] = 1'b1;
            psp_pkg::CH_0:     ctl_nxt.flags[psp_pkg::FLG_ZERO]  = 1'b1;
            psp_pkg::CH_PLUS:  ctl_nxt.flags[psp_pkg::FLG_PLUS]  = 1'b1;
            psp_pkg::CH_SPACE: ctl_nxt.flags[psp_pkg::FLG_SPACE] = 1'b1;
            default:           ctl_nxt.flags[psp_pkg::FLG_HASH]  = 1'b1;
          endcase
          consume = 1'b1;
        end else if (ch == psp_pkg::CH_STAR) begin
          if (neg) ctl_nxt.flags[psp_pkg::FLG_MINUS] = 1'b1;
          width_nxt     = star_val;
          ctl_nxt.phase = psp_pkg::PH_WDONE;
          consume       = 1'b1;
        end else if (is_digit) begin
          width_nxt     = dig_val;
          ctl_nxt.phase = psp_pkg::PH_WDIG;
          consume       = 1'b1;
        end else begin
          tail_req = 1'b1;
          tail_dot = 1'b1;
        end
      end
      psp_pkg::PH_WDIG: begin
        if (is_digit) begin
          width_nxt = dig_val;
          consume   = 1'b1;
        end else begin
          tail_req = 1'b1;
          tail_dot = 1'b1;
        end
      end
      psp_pkg::PH_WDONE: begin
        tail_req = 1'b1;
        tail_dot = 1'b1;
      end
      psp_pkg::PH_PSTART: begin
        if (ch == psp_pkg::CH_STAR) begin
          if (neg) begin
            ctl_nxt.prec_present = 1'b0;
            prec_nxt             = '0;
          end else begin
            prec_nxt = star_val;
          end
          ctl_nxt.phase = psp_pkg::PH_PDONE;
          consume       = 1'b1;
        end else if (is_digit) begin
          prec_nxt      = dig_val;
          ctl_nxt.phase = psp_pkg::PH_PDIG;
          consume       = 1'b1;
        end else begin
          tail_req = 1'b1;
        end
      end
      psp_pkg::PH_PDIG: begin
        if (is_digit) begin
          prec_nxt = dig_val;
          consume  = 1'b1;
        end else begin
          tail_req = 1'b1;
        end
      end
      psp_pkg::PH_PDONE: begin
        tail_req = 1'b1;
      end
      psp_pkg::PH_LEN_H: begin
        if (ch == psp_pkg::CH_H) begin
          ctl_nxt.len   = psp_pkg::LEN_HH;
          ctl_nxt.phase = psp_pkg::PH_CONV;
          consume       = 1'b1;
        end else begin
          emit_req = 1'b1;
        end
      end
      psp_pkg::PH_LEN_L: begin
        if (ch == psp_pkg::CH_L) begin
          ctl_nxt.len   = psp_pkg::LEN_LL;
          ctl_nxt.phase = psp_pkg::PH_CONV;
          consume       = 1'b1;
        end else begin
          emit_req = 1'b1;
        end
      end
      default: begin
        emit_req = 1'b1;
      end
    endcase

    // Precision start, length modifier, or else the conversion byte
    if (tail_req) begin
      if (tail_dot && ch == psp_pkg::CH_DOT) begin
        ctl_nxt.prec_present = 1'b1;
        prec_nxt             = '0;
        ctl_nxt.phase        = psp_pkg::PH_PSTART;
        consume              = 1'b1;
      end else if (ch == psp_pkg::CH_H) begin
        ctl_nxt.len   = psp_pkg::LEN_H;
        ctl_nxt.phase = psp_pkg::PH_LEN_H;
        consume       = 1'b1;
      end else if (ch == psp_pkg::CH_L) begin
        ctl_nxt.len   = psp_pkg::LEN_L;
        ctl_nxt.phase = psp_pkg::PH_LEN_L;
        consume       = 1'b1;
      end else if (ch == psp_pkg::CH_Z) begin
        ctl_nxt.len   = psp_pkg::LEN_Z;
        ctl_nxt.phase = psp_pkg::PH_CONV;
        consume       = 1'b1;
      end else begin
        emit_req = 1'b1;
      end
    end

    if (consume) cnt_nxt = cnt_bump;

    // Build the result from the state before this byte
    result_o.left_just   = ctl_i.flags[psp_pkg::FLG_MINUS];
    result_o.fill_zero   = ctl_i.flags[psp_pkg::FLG_ZERO];
    result_o.plus_sign   = ctl_i.flags[psp_pkg::FLG_PLUS];
    result_o.blank_sign  = ctl_i.flags[psp_pkg::FLG_SPACE];
    result_o.hash_style  = ctl_i.flags[psp_pkg::FLG_HASH];
    result_o.field_width = 31'(width_i);
    result_o.has_prec    = ctl_i.prec_present;
    result_o.prec_value  = 31'(prec_i);
    result_o.length_code = ctl_i.len;
    result_o.conversion  = ch;
    result_o.consumed    = (ch != psp_pkg::CH_NUL) ? 16'(cnt_bump) : 16'(cnt_i);

    // End of specification: back to the flags phase with cleared fields
    if (emit_req) begin
      ctl_nxt.phase        = psp_pkg::PH_FLAGS;
      ctl_nxt.flags        = '0;
      ctl_nxt.prec_present = 1'b0;
      ctl_nxt.len          = psp_pkg::LEN_NONE;
      width_nxt            = '0;
      prec_nxt             = '0;
      cnt_nxt              = '0;
    end
    emit_o = emit_req;
  end

endmodule
